// ===== sv/hgq_pkg.sv =====
// Shared types, constants and codes of the Hessenberg Givens QR block.
`timescale 1ns / 1ps

package hgq_pkg;

  localparam int MAX_COLS = 16;
  localparam int NROWS    = MAX_COLS + 1;
  localparam int NCELL    = MAX_COLS + 1;
  localparam int VW       = 32;
  localparam int FRAC     = VW - 5;
  localparam int RW       = $clog2(NROWS);
  localparam int CIW      = $clog2(NCELL);
  localparam int NW       = $clog2(MAX_COLS + 1);
  localparam int KW       = FRAC + 2;
  localparam int QB       = FRAC + 1;

  localparam logic [2:0] KIND_WR_MAT = 3'd0;
  localparam logic [2:0] KIND_WR_VEC = 3'd1;
  localparam logic [2:0] KIND_RUN    = 3'd2;
  localparam logic [2:0] KIND_RD_MAT = 3'd3;
  localparam logic [2:0] KIND_RD_VEC = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_PIV, S_PIVW, S_SQ, S_SUM, S_ROOT, S_DIV,
    S_DRAIN, S_SETTLE, S_NEXT, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [4:0]        row;
    logic [3:0]        col;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic [RW-1:0]        row;
    logic signed [KW-1:0] c;
    logic signed [KW-1:0] s;
    logic signed [VW-1:0] r;
  } tok_t;

  typedef struct packed {
    logic [RW-1:0]        wrow;
    logic signed [VW-1:0] wdata;
    logic [RW-1:0]        rrow_a;
    logic [RW-1:0]        rrow_b;
    logic [NW-1:0]        ncols;
  } cell_req_t;

endpackage

// ===== sv/hgq_cell.sv =====
// One column cell: column store plus the rotation update, token passed on each cycle.
`timescale 1ns / 1ps

module hgq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [hgq_pkg::CIW-1:0]          cell_id,
  input  hgq_pkg::cell_req_t               req,
  input  logic                             we,
  input  hgq_pkg::tok_t                    tk_in,
  output hgq_pkg::tok_t                    tk_out,
  output logic signed [hgq_pkg::VW-1:0]    qa,
  output logic signed [hgq_pkg::VW-1:0]    qb,
  output logic                             sat
);

  localparam int VW  = hgq_pkg::VW;
  localparam int PRW = hgq_pkg::KW + VW;
  localparam int SW  = PRW + 1;
  localparam int SHW = SW - hgq_pkg::FRAC;

  logic signed [VW-1:0] mem [hgq_pkg::NROWS];
  logic [hgq_pkg::RW-1:0] ra, rb;

  hgq_pkg::tok_t tk1, tk2;
  logic act2, dg2;
  logic signed [PRW-1:0] pcx, psy, psx, pcy;
  logic signed [SW-1:0]  t_full, u_full;
  logic [VW:0]           ct, cu;
  logic                  wr2, wr3;
  logic [hgq_pkg::RW-1:0] row3;
  logic signed [VW-1:0]  u3;
  logic                  is_vec, act1, dg1;

  function automatic logic [VW:0] clampv(input logic signed [SHW-1:0] v);
    logic [SHW-VW:0] hi;
    hi = v[SHW-1:VW-1];
    if (hi == '0 || hi == '1) return {1'b0, v[VW-1:0]};
    else if (v[SHW-1]) return {1'b1, 1'b1, {(VW-1){1'b0}}};
    else return {1'b1, 1'b0, {(VW-1){1'b1}}};
  endfunction

  assign ra = tk_in.valid ? tk_in.row : req.rrow_a;
  assign rb = tk_in.valid ? hgq_pkg::RW'(tk_in.row + 1'b1) : req.rrow_b;

  assign is_vec = (cell_id == hgq_pkg::CIW'(hgq_pkg::MAX_COLS));
  assign act1 = is_vec || (cell_id > tk1.row && hgq_pkg::NW'(cell_id) < req.ncols);
  assign dg1  = !is_vec && (cell_id == tk1.row);

  assign tk_out = tk1;

  // stage two: combine products, drop fraction bits, clamp
  assign t_full = SW'(pcx) - SW'(psy);
  assign u_full = SW'(psx) + SW'(pcy);
  assign ct = clampv($signed(t_full[SW-1:hgq_pkg::FRAC]));
  assign cu = clampv($signed(u_full[SW-1:hgq_pkg::FRAC]));
  assign wr2 = tk2.valid && (act2 || dg2);
  assign sat = tk2.valid && act2 && (ct[VW] || cu[VW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tk1.valid <= 1'b0;
      tk2.valid <= 1'b0;
      wr3       <= 1'b0;
    end else begin
      tk1.valid <= tk_in.valid;
      tk2.valid <= tk1.valid;
      wr3       <= wr2;
    end
    tk1.row <= tk_in.row;
    tk1.c   <= tk_in.c;
    tk1.s   <= tk_in.s;
    tk1.r   <= tk_in.r;
    tk2.row <= tk1.row;
    tk2.c   <= tk1.c;
    tk2.s   <= tk1.s;
    tk2.r   <= tk1.r;
    act2 <= act1;
    dg2  <= dg1;
    pcx  <= tk1.c * qa;
    psy  <= tk1.s * qb;
    psx  <= tk1.s * qa;
    pcy  <= tk1.c * qb;
    row3 <= hgq_pkg::RW'(tk2.row + 1'b1);
    u3   <= dg2 ? '0 : $signed(cu[VW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (wr2) begin
      mem[tk2.row] <= dg2 ? tk2.r : $signed(ct[VW-1:0]);
    end else if (wr3) begin
      mem[row3] <= u3;
    end else if (we) begin
      mem[req.wrow] <= req.wdata;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

// ===== sv/hgq_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module hgq_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad_in,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [34:0] rem, remn, trial;
  logic [4:0]  cnt;
  logic        run;
  logic        ge;

  assign remn  = {rem[32:0], rad[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = (remn >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 5'd31) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (run) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= ge ? remn - trial : remn;
      root <= {root[30:0], ge};
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

// ===== sv/hgq_div.sv =====
// Restoring divider for the rotation factor: (m << FRAC) / d with m <= d.
`timescale 1ns / 1ps

module hgq_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            m,
  input  logic [31:0]            d,
  output logic                   done,
  output logic [hgq_pkg::QB-1:0] q
);

  localparam int CNW = $clog2(hgq_pkg::QB);

  logic [32:0]    rem, diff;
  logic [31:0]    dv;
  logic [CNW-1:0] cnt;
  logic           run, ge;

  assign ge   = (rem >= {1'b0, dv});
  assign diff = ge ? rem - {1'b0, dv} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNW'(hgq_pkg::QB - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= {1'b0, m};
      dv  <= d;
      q   <= '0;
      cnt <= '0;
    end else if (run) begin
      rem <= {diff[31:0], 1'b0};
      q   <= {q[hgq_pkg::QB-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== sv/hessenberg_givens_qr.sv =====
// Top level: command decode, rotation sequencer and the row of column cells.
`timescale 1ns / 1ps

// Givens QR of an upper Hessenberg matrix held in a row of column cells.
// Command channel: a word on cmd is taken at a rising edge with start high and
// busy low. Kinds: write matrix entry, write vector entry, run, read matrix,
// read vector. Every word gives exactly one result word on result, shown for
// one cycle with done high; the receiver cannot stall, so none is held.
// Loads and reads: the result is registered in the response state from the
// registered read port of the addressed cell; busy stays high until it is shown.
// Run: each rotation reads the pivot pair, squares it, takes the square root,
// runs two parallel dividers, then sends the token down the 17 cells and settles;
// a full run has up to 16 rotations; a zero pair skips root, divide and token.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 active_cols,
// 1 size_limit) and cfg_data; ready is always high, write only while idle.
// Reset (rst, synchronous): active_cols 16, size_limit 17, run status 0.
// Matrix and vector stores are not cleared; read only entries once written.

module hessenberg_givens_qr (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  hgq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output hgq_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data
);

  localparam int VW    = hgq_pkg::VW;
  localparam int NCELL = hgq_pkg::NCELL;
  localparam int RW    = hgq_pkg::RW;
  localparam int CIW   = hgq_pkg::CIW;
  localparam int NW    = hgq_pkg::NW;
  localparam int KW    = hgq_pkg::KW;
  localparam int QB    = hgq_pkg::QB;
  localparam logic [1:0] CFG_ACTIVE_COLS = 2'd0;
  localparam logic [1:0] CFG_SIZE_LIMIT  = 2'd1;
  localparam logic [1:0] SETTLE_LAST     = 2'd2;

  hgq_pkg::state_t state, state_next;

  // configuration and run bookkeeping
  logic [4:0]   active_cols, size_limit;
  logic [NW-1:0] ncols;
  logic [4:0]   rot_cnt;
  logic [RW-1:0] i_rot;
  logic         zero_f, sat_f;
  logic [1:0]   run_flags;
  logic [1:0]   settle;

  // command context held through the response
  logic [2:0]    cur_kind;
  logic [CIW-1:0] sel_cell;
  logic [1:0]    st_pend;
  logic          rd_ok;
  logic          acc, mok, vok;

  // rotation datapath
  logic signed [VW-1:0] a_reg, b_reg;
  logic [63:0]          aa, bb;
  logic [31:0]          mag_a, mag_b;
  logic                 sq_start, sq_done;
  logic [31:0]          root;
  logic                 dv_start, dc_done, ds_done;
  logic [QB-1:0]        qc, qs;
  hgq_pkg::tok_t        tk0;

  // cell row
  hgq_pkg::cell_req_t   creq;
  logic [NCELL-1:0]     cwe, csat;
  hgq_pkg::tok_t        tkc [NCELL];
  logic signed [VW-1:0] cqa [NCELL];
  logic signed [VW-1:0] cqb [NCELL];
  logic signed [VW-1:0] qa_sel, qb_sel;

  assign cfg_ready = 1'b1;

  assign ncols   = (active_cols > 5'(hgq_pkg::MAX_COLS)) ? NW'(hgq_pkg::MAX_COLS)
                                                         : NW'(active_cols);
  assign rot_cnt = (size_limit == 5'd0) ? 5'd0 :
                   (5'(ncols) < size_limit) ? 5'(ncols) : size_limit - 5'd1;

  assign acc = start && !busy;
  assign mok = (cmd.row < 5'(hgq_pkg::NROWS));
  assign vok = (cmd.row < 5'(hgq_pkg::NROWS));

  assign qa_sel = cqa[sel_cell];
  assign qb_sel = cqb[sel_cell];
  assign mag_a  = a_reg[VW-1] ? 32'(-a_reg) : 32'(a_reg);
  assign mag_b  = b_reg[VW-1] ? 32'(-b_reg) : 32'(b_reg);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hgq_pkg::S_IDLE: begin
        if (acc) begin
          if (cmd.kind == hgq_pkg::KIND_RUN) begin
            state_next = (rot_cnt == 5'd0) ? hgq_pkg::S_DONE : hgq_pkg::S_PIV;
          end else begin
            state_next = hgq_pkg::S_RESP;
          end
        end
      end
      hgq_pkg::S_RESP:  state_next = hgq_pkg::S_IDLE;
      hgq_pkg::S_PIV:   state_next = hgq_pkg::S_PIVW;
      hgq_pkg::S_PIVW:  state_next = hgq_pkg::S_SQ;
      hgq_pkg::S_SQ: begin
        state_next = (a_reg == '0 && b_reg == '0) ? hgq_pkg::S_NEXT : hgq_pkg::S_SUM;
      end
      hgq_pkg::S_SUM:   state_next = hgq_pkg::S_ROOT;
      hgq_pkg::S_ROOT:  if (sq_done) state_next = hgq_pkg::S_DIV;
      hgq_pkg::S_DIV:   if (dc_done && ds_done) state_next = hgq_pkg::S_DRAIN;
      hgq_pkg::S_DRAIN: if (tkc[NCELL-1].valid) state_next = hgq_pkg::S_SETTLE;
      hgq_pkg::S_SETTLE: if (settle == SETTLE_LAST) state_next = hgq_pkg::S_NEXT;
      hgq_pkg::S_NEXT: begin
        state_next = (5'(i_rot) + 5'd1 == rot_cnt) ? hgq_pkg::S_DONE : hgq_pkg::S_PIV;
      end
      hgq_pkg::S_DONE:  state_next = hgq_pkg::S_RESP;
      default:          state_next = hgq_pkg::S_IDLE;
    endcase
  end

  // control outputs: busy, unit starts, cell request bus, write enables
  always_comb begin
    busy        = (state != hgq_pkg::S_IDLE);
    sq_start    = (state == hgq_pkg::S_SUM);
    dv_start    = (state == hgq_pkg::S_ROOT) && sq_done;
    creq.wrow   = cmd.row;
    creq.wdata  = cmd.value;
    creq.ncols  = ncols;
    creq.rrow_a = (state == hgq_pkg::S_PIV) ? i_rot : cmd.row;
    creq.rrow_b = RW'(i_rot + 1'b1);
    for (int j = 0; j < NCELL; j++) begin
      cwe[j] = 1'b0;
      if (acc && mok && cmd.kind == hgq_pkg::KIND_WR_MAT && 5'(cmd.col) == 5'(j)) begin
        cwe[j] = 1'b1;
      end
      if (acc && vok && cmd.kind == hgq_pkg::KIND_WR_VEC && j == hgq_pkg::MAX_COLS) begin
        cwe[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hgq_pkg::S_IDLE;
      active_cols <= 5'd16;
      size_limit  <= 5'd17;
      run_flags   <= hgq_pkg::STAT_OK;
      done        <= 1'b0;
      tk0.valid   <= 1'b0;
    end else begin
      state     <= state_next;
      done      <= (state == hgq_pkg::S_RESP);
      tk0.valid <= (state == hgq_pkg::S_DIV) && dc_done && ds_done;
      if (cfg_valid) begin
        if (cfg_index == CFG_ACTIVE_COLS) active_cols <= cfg_data;
        else if (cfg_index == CFG_SIZE_LIMIT) size_limit <= cfg_data;
      end
      if (state == hgq_pkg::S_DONE) begin
        run_flags <= sat_f ? hgq_pkg::STAT_SAT :
                     zero_f ? hgq_pkg::STAT_ZERO : hgq_pkg::STAT_OK;
      end
    end

    unique case (state)
      hgq_pkg::S_IDLE: begin
        if (acc) begin
          cur_kind <= cmd.kind;
          sel_cell <= (cmd.kind == hgq_pkg::KIND_RD_VEC) ? CIW'(hgq_pkg::MAX_COLS)
                                                       : CIW'(cmd.col);
          rd_ok    <= (cmd.kind == hgq_pkg::KIND_RD_MAT && mok) ||
                      (cmd.kind == hgq_pkg::KIND_RD_VEC && vok);
          zero_f   <= 1'b0;
          sat_f    <= 1'b0;
          i_rot    <= '0;
          priority if (cmd.kind == hgq_pkg::KIND_WR_MAT || cmd.kind == hgq_pkg::KIND_RD_MAT) begin
            st_pend <= mok ? hgq_pkg::STAT_OK : hgq_pkg::STAT_RANGE;
          end else if (cmd.kind == hgq_pkg::KIND_WR_VEC ||
                       cmd.kind == hgq_pkg::KIND_RD_VEC) begin
            st_pend <= vok ? hgq_pkg::STAT_OK : hgq_pkg::STAT_RANGE;
          end else begin
            st_pend <= hgq_pkg::STAT_RANGE;
          end
        end
      end
      hgq_pkg::S_RESP: begin
        result.read_value <= rd_ok ? qa_sel : '0;
        result.status     <= (cur_kind == hgq_pkg::KIND_RUN) ? run_flags : st_pend;
      end
      hgq_pkg::S_PIV: sel_cell <= CIW'(i_rot);
      hgq_pkg::S_PIVW: begin
        a_reg <= qa_sel;
        b_reg <= qb_sel;
      end
      hgq_pkg::S_SQ: begin
        if (a_reg == '0 && b_reg == '0) zero_f <= 1'b1;
        aa <= 64'(mag_a) * 64'(mag_a);
        bb <= 64'(mag_b) * 64'(mag_b);
      end
      hgq_pkg::S_DIV: begin
        // hand the rotation to the first cell; clamp r for the diagonal
        tk0.row <= i_rot;
        tk0.c   <= a_reg[VW-1] ? -$signed(KW'(qc)) : $signed(KW'(qc));
        tk0.s   <= (!b_reg[VW-1] && b_reg != '0) ? -$signed(KW'(qs)) : $signed(KW'(qs));
        tk0.r   <= root[31] ? $signed({1'b0, {(VW-1){1'b1}}}) : $signed(root);
        if (dc_done && ds_done && root[31]) sat_f <= 1'b1;
        settle  <= '0;
      end
      // gather saturation from the cells while a rotation drains and settles
      hgq_pkg::S_DRAIN: sat_f <= sat_f | (|csat);
      hgq_pkg::S_SETTLE: begin
        settle <= settle + 2'd1;
        sat_f  <= sat_f | (|csat);
      end
      hgq_pkg::S_NEXT:   i_rot <= RW'(i_rot + 1'b1);
      default: ;
    endcase
  end

  hgq_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .rad_in (aa + bb),
    .done   (sq_done),
    .root   (root)
  );

  hgq_div u_div_c (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .m     (mag_a),
    .d     (root),
    .done  (dc_done),
    .q     (qc)
  );

  hgq_div u_div_s (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .m     (mag_b),
    .d     (root),
    .done  (ds_done),
    .q     (qs)
  );

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    hgq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (CIW'(j)),
      .req     (creq),
      .we      (cwe[j]),
      .tk_in   ((j == 0) ? tk0 : tkc[(j == 0) ? 0 : j - 1]),
      .tk_out  (tkc[j]),
      .qa      (cqa[j]),
      .qb      (cqb[j]),
      .sat     (csat[j])
    );
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the Hessenberg Givens QR block.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CFG_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_LIMIT  = 2'd1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MC = hgq_pkg::MAX_COLS;
  localparam int NR = hgq_pkg::MAX_COLS + 1;
  localparam longint VMAXL = 64'sd2147483647;
  localparam longint VMINL = -64'sd2147483648;

  // One queued word: either a command or a register write.
  typedef struct {
    bit             is_cfg;
    logic [1:0]     idx;
    logic [4:0]     data;
    hgq_pkg::cmd_t  c;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  hgq_pkg::cmd_t cmd = '0;
  logic busy, done, cfg_ready;
  hgq_pkg::res_t result;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  pend_t          pending[$];
  hgq_pkg::res_t  expected_res[$];
  int     errors = 0;
  int     cycle_count = 0;
  int     accepted = 0;

  // Shadow copy of the block's state and registers.
  longint mat_shadow[NR*MC];
  longint vec_shadow[NR];
  int     active_shadow = 16;
  int     limit_shadow = 17;
  bit     sat_hit;

  hessenberg_givens_qr dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  function automatic longint clamp32(input logic signed [127:0] x);
    if (x > 128'(VMAXL)) begin
      sat_hit = 1'b1;
      return VMAXL;
    end
    if (x < 128'(VMINL)) begin
      sat_hit = 1'b1;
      return VMINL;
    end
    return longint'(x);
  endfunction

  // (c*x + d*y) shifted down by the fraction bits, floor, then saturated.
  function automatic longint rot_mac(input longint c, input longint x,
                                     input longint d, input longint y);
    logic signed [127:0] acc;
    acc = 128'(c) * 128'(x) + 128'(d) * 128'(y);
    acc = acc >>> hgq_pkg::FRAC;
    return clamp32(acc);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [1:0] givens_run();
    int n, cnt;
    bit zero_hit;
    longint a, b, c, s, x, y, t;
    logic [63:0] r, ma, mb;
    logic [127:0] sq;
    n = active_shadow > MC ? MC : active_shadow;
    if (limit_shadow == 0) cnt = 0;
    else cnt = n < limit_shadow ? n : limit_shadow - 1;
    zero_hit = 1'b0;
    sat_hit = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      a = mat_shadow[i*MC + i];
      b = mat_shadow[(i+1)*MC + i];
      if (a == 0 && b == 0) begin
        zero_hit = 1'b1;
        continue;
      end
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      sq = {64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb};
      r = floor_sqrt(sq);
      c = longint'((ma << hgq_pkg::FRAC) / r);
      if (a < 0) c = -c;
      s = longint'((mb << hgq_pkg::FRAC) / r);
      if (b > 0) s = -s;
      if (r > 64'(VMAXL)) begin
        sat_hit = 1'b1;
        r = 64'(VMAXL);
      end
      mat_shadow[i*MC + i] = longint'(r);
      mat_shadow[(i+1)*MC + i] = 0;
      for (int j = i + 1; j < n; j++) begin
        x = mat_shadow[i*MC + j];
        y = mat_shadow[(i+1)*MC + j];
        t = rot_mac(c, x, -s, y);
        mat_shadow[(i+1)*MC + j] = rot_mac(s, x, c, y);
        mat_shadow[i*MC + j] = t;
      end
      x = vec_shadow[i];
      y = vec_shadow[i+1];
      t = rot_mac(c, x, -s, y);
      vec_shadow[i+1] = rot_mac(s, x, c, y);
      vec_shadow[i] = t;
    end
    return sat_hit ? hgq_pkg::STAT_SAT : (zero_hit ? hgq_pkg::STAT_ZERO : hgq_pkg::STAT_OK);
  endfunction

  function automatic hgq_pkg::res_t predict_word(input hgq_pkg::cmd_t c);
    hgq_pkg::res_t r;
    bit row_ok;
    r = '0;
    row_ok = c.row < NR;
    case (c.kind)
      hgq_pkg::KIND_WR_MAT: begin
        if (!row_ok) r.status = hgq_pkg::STAT_RANGE;
        else mat_shadow[c.row*MC + c.col] = longint'(c.value);
      end
      hgq_pkg::KIND_WR_VEC: begin
        if (!row_ok) r.status = hgq_pkg::STAT_RANGE;
        else vec_shadow[c.row] = longint'(c.value);
      end
      hgq_pkg::KIND_RUN: r.status = givens_run();
      hgq_pkg::KIND_RD_MAT: begin
        if (!row_ok) r.status = hgq_pkg::STAT_RANGE;
        else r.read_value = 32'(mat_shadow[c.row*MC + c.col]);
      end
      hgq_pkg::KIND_RD_VEC: begin
        if (!row_ok) r.status = hgq_pkg::STAT_RANGE;
        else r.read_value = 32'(vec_shadow[c.row]);
      end
      default: r.status = hgq_pkg::STAT_RANGE;
    endcase
    return r;
  endfunction

  function automatic pend_t mk_cmd(input logic [2:0] k, input int row, input int col,
                                   input logic [31:0] v);
    pend_t p;
    p.is_cfg = 1'b0;
    p.idx = '0;
    p.data = '0;
    p.c.kind = k;
    p.c.row = 5'(row);
    p.c.col = 4'(col);
    p.c.value = v;
    return p;
  endfunction

  function automatic pend_t mk_cfg(input logic [1:0] idx, input int data);
    pend_t p;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = 5'(data);
    p.c = '0;
    return p;
  endfunction

  // Mostly values between minus one and one in Q4.27, sometimes any 32-bit pattern.
  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
  endfunction

  // Append one word to the end of the pending queue.
  task automatic enqueue(input pend_t p);
    pending = {pending, p};
  endtask

  // Driver: count accepted words, predict them, and feed the next word.
  always @(posedge clk) begin
    bit idle_now;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ACTIVE) active_shadow = cfg_data;
        else if (cfg_index == CFG_LIMIT) limit_shadow = cfg_data;
        cfg_valid <= 1'b0;
      end
      if (start && !busy) begin
        expected_res = {expected_res, predict_word(cmd)};
        accepted++;
      end
      if (!(start && busy) && !(cfg_valid && !cfg_ready)) begin
        // long idle-free stretch in the middle of the run
        idle_now = !(accepted >= 180 && accepted < 300) && ($urandom_range(0, 99) < 36);
        if (pending.size() == 0 || idle_now) begin
          start <= 1'b0;
        end else if (pending[0].is_cfg) begin
          // drain everything before touching a register
          start <= 1'b0;
          if (!start && !busy && !cfg_valid && expected_res.size() == 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= pending[0].idx;
            cfg_data <= pending[0].data;
            void'(pending.pop_front());
          end
        end else begin
          start <= 1'b1;
          cmd <= pending.pop_front().c;
        end
      end
    end
  end

  // Monitor: every strobed result word must match the oldest prediction.
  always @(posedge clk) begin
    hgq_pkg::res_t want;
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", result.read_value, 0);
      end else begin
        want = expected_res.pop_front();
        if (result.read_value !== want.read_value)
          report_mismatch("read_value", result.read_value, want.read_value);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL hessenberg_givens_qr");
      $finish;
    end
  end

  initial begin
    int k, r, sel;
    // Load every entry so that no read or run touches an unwritten one.
    for (int i = 0; i < NR; i++)
      for (int j = 0; j < MC; j++)
        enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, i, j, rand_value()));
    for (int i = 0; i < NR; i++) enqueue(mk_cmd(hgq_pkg::KIND_WR_VEC, i, 0, rand_value()));

    // Directed words: value extremes, bad index, bad kinds, zero pair, config extremes.
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 16, 15, 32'h7fff_ffff));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_MAT, 16, 15, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_VEC, 0, 0, 32'h8000_0000));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_VEC, 0, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 31, 3, 32'h1234_5678));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_VEC, 17, 0, 32'h1));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_MAT, 17, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_VEC, 31, 0, '0));
    enqueue(mk_cmd(3'd5, 0, 0, '0));
    enqueue(mk_cmd(3'd6, 1, 1, '1));
    enqueue(mk_cmd(3'd7, 2, 2, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 0, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 1, 0, '0));
    enqueue(mk_cfg(CFG_ACTIVE, 1));
    enqueue(mk_cfg(CFG_LIMIT, 2));
    enqueue(mk_cmd(hgq_pkg::KIND_RUN, 0, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_MAT, 0, 0, '0));
    enqueue(mk_cfg(CFG_ACTIVE, 16));
    enqueue(mk_cfg(CFG_LIMIT, 17));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 0, 0, 32'h8000_0000));
    enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, 1, 0, 32'h8000_0000));
    enqueue(mk_cmd(hgq_pkg::KIND_RUN, 0, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_MAT, 0, 0, '0));
    enqueue(mk_cmd(hgq_pkg::KIND_RD_VEC, 16, 0, '0));

    // Random words, with a register change now and then.
    for (int n = 0; n < 90; n++) begin
      if (n % 60 == 59) begin
        enqueue(mk_cfg(CFG_ACTIVE, $urandom_range(1, 16)));
        enqueue(mk_cfg(CFG_LIMIT, $urandom_range(2, 17)));
      end
      sel = $urandom_range(0, 99);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
      k = $urandom_range(0, 15);
      if (sel < 38) enqueue(mk_cmd(hgq_pkg::KIND_WR_MAT, r, k, rand_value()));
      else if (sel < 52) enqueue(mk_cmd(hgq_pkg::KIND_WR_VEC, r, k, rand_value()));
      else if (sel < 60) enqueue(mk_cmd(hgq_pkg::KIND_RUN, r, k, $urandom));
      else if (sel < 85) enqueue(mk_cmd(hgq_pkg::KIND_RD_MAT, r, k, $urandom));
      else if (sel < 96) enqueue(mk_cmd(hgq_pkg::KIND_RD_VEC, r, k, $urandom));
      else enqueue(mk_cmd(3'($urandom_range(5, 7)), r, k, $urandom));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for the queue to empty and the last result to arrive.
    while (!(pending.size() == 0 && !start && !cfg_valid && expected_res.size() == 0))
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASS hessenberg_givens_qr");
    end else begin
      $display("FAIL hessenberg_givens_qr");
    end
    $finish;
  end

endmodule
